// ===== rtl/mm3fm_pkg.sv =====
// package for the multichannel median-of-three fault monitor
// shared widths, register map, transaction structs and the median function
`timescale 1ns / 1ps

package mm3fm_pkg;

  localparam int unsigned NumChannelsDef = 5;
  localparam int unsigned JackW = 3;
  localparam int unsigned ChanW = 3;
  localparam int unsigned TempW = 16;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  typedef enum logic {
    RegGrillJack = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0]        chan;
    logic signed [TempW-1:0] raw;
    logic                    enabled;
  } sample_t;

  typedef struct packed {
    logic [ChanW-1:0]        chan;
    logic signed [TempW-1:0] filt;
    logic                    fault;
    logic                    chg_event;
  } result_t;

  function automatic logic signed [TempW-1:0] median3(
    input logic signed [TempW-1:0] a,
    input logic signed [TempW-1:0] b,
    input logic signed [TempW-1:0] c
  );
    logic signed [TempW-1:0] lo;
    logic signed [TempW-1:0] hi;
    logic signed [TempW-1:0] hc;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hc = (hi < c) ? hi : c;
    median3 = (lo > hc) ? lo : hc;
  endfunction

endpackage

// ===== rtl/mm3fm_cfg.sv =====
// apb-style configuration register block, holds the grill jack selection
// depends on mm3fm_pkg
`timescale 1ns / 1ps

module mm3fm_cfg
  import mm3fm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [JackW-1:0]  grill_jack_o
);

  logic [JackW-1:0] grill_jack_q;
  logic             sel_grill;
  logic             wr_grill;

  assign sel_grill = (paddr[PaddrW-1] == RegGrillJack);
  assign wr_grill  = psel && penable && pwrite && pready && sel_grill;
  assign pready    = 1'b1;
  assign prdata    = sel_grill ? {{(PdataW-JackW){1'b0}}, grill_jack_q} : '0;
  assign grill_jack_o = grill_jack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grill_jack_q <= '0;
    end else if (wr_grill) begin
      grill_jack_q <= pwdata[JackW-1:0];
    end
  end

endmodule

// ===== rtl/mm3fm_chan_state.sv =====
// per-channel sample rings, warm-up counts and fault flags with the filter datapath
// depends on mm3fm_pkg
`timescale 1ns / 1ps

module mm3fm_chan_state
  import mm3fm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  sample_t sample_i,
  output result_t result_o
);

  localparam int unsigned ChIdxW = $clog2(NUM_CHANNELS);

  logic signed [TempW-1:0] ring_q [NUM_CHANNELS][3];
  logic [1:0]              pos_q [NUM_CHANNELS];
  logic [1:0]              warm_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] seen_q;
  logic [NUM_CHANNELS-1:0] last_q;

  logic [ChIdxW-1:0]       idx;
  logic [1:0]              pos;
  logic [1:0]              pos_d;
  logic [1:0]              warm;
  logic [1:0]              warm_d;
  logic signed [TempW-1:0] r0, r1, r2;
  logic signed [TempW-1:0] filt;
  logic                    fault;
  logic                    seen_d;
  logic                    in_use;

  always_comb begin
    idx    = ChIdxW'(sample_i.chan);
    pos    = (pos_q[idx] == 2'd3) ? 2'd0 : pos_q[idx];
    pos_d  = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
    warm   = warm_q[idx];
    warm_d = (warm < 2'd2) ? warm + 2'd1 : warm;
    r0     = (pos == 2'd0) ? sample_i.raw : ring_q[idx][0];
    r1     = (pos == 2'd1) ? sample_i.raw : ring_q[idx][1];
    r2     = (pos == 2'd2) ? sample_i.raw : ring_q[idx][2];
    filt   = (warm >= 2'd2) ? median3(r0, r1, r2) : sample_i.raw;
    fault  = (filt <= 0);
    seen_d = seen_q[idx] || !fault;
    in_use = (sample_i.chan == '0) || sample_i.enabled;

    result_o.chan      = sample_i.chan;
    result_o.filt      = filt;
    result_o.fault     = fault;
    result_o.chg_event = in_use && seen_d && (fault != last_q[idx]);
  end

  // ring payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_q[idx][pos] <= sample_i.raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_q[i]  <= '0;
        warm_q[i] <= '0;
      end
      seen_q <= '0;
      last_q <= '0;
    end else if (wr_en_i) begin
      pos_q[idx]  <= pos_d;
      warm_q[idx] <= warm_d;
      seen_q[idx] <= seen_d;
      last_q[idx] <= fault;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> (pos_q[$past(idx)] != 2'd3))
    else $error("ring position left its range");

  a_warm_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> (warm_q[$past(idx)] != 2'd3))
    else $error("warm-up count passed its saturation value");

  a_event_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && result_o.chg_event) |=> seen_q[$past(idx)])
    else $error("change event on a channel never seen valid");
`endif

endmodule

// ===== rtl/multichannel_median3_fault_monitor_top.sv =====
// Median-of-three temperature filter and fault monitor over NUM_CHANNELS sensor channels.
// One sample transaction is taken every clock cycle while in_stall_o is low; it is first
// held in an input register, and then the channel state is read, filtered and written
// back in the same cycle as the result is captured into the result register, so each
// sample of a channel sees the state left by the sample before it. A sample
// from a jack of NUM_CHANNELS or above gives no result and changes no state.
// depends on mm3fm_pkg, mm3fm_cfg and mm3fm_chan_state
`timescale 1ns / 1ps

module multichannel_median3_fault_monitor_top
  import mm3fm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrW-1:0]       paddr,
  input  logic [PdataW-1:0]       pwdata,
  output logic [PdataW-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [JackW-1:0]        jack_i,
  input  logic signed [TempW-1:0] raw_temp_i,
  input  logic                    probe_enabled_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ChanW-1:0]        channel_o,
  output logic signed [TempW-1:0] filtered_temp_o,
  output logic                    is_fault_o,
  output logic                    change_event_o
);

  logic [JackW-1:0]        grill_jack;
  logic [JackW-1:0]        gj_eff;

  logic                    s1_valid_q;
  logic [JackW-1:0]        s1_jack_q;
  logic signed [TempW-1:0] s1_raw_q;
  logic                    s1_en_q;

  logic                    s1_hit;
  logic                    s1_move;
  logic                    out_free;
  logic                    in_accept;
  logic                    wr_en;
  sample_t                 sample;
  result_t                 result;

  logic                    out_valid_q;
  result_t                 out_q;

  mm3fm_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .grill_jack_o (grill_jack)
  );

  // jack to logical channel mapping
  always_comb begin
    gj_eff = (32'(grill_jack) >= 32'(NUM_CHANNELS)) ? '0 : grill_jack;
    if (s1_jack_q == gj_eff) begin
      sample.chan = '0;
    end else if (s1_jack_q < gj_eff) begin
      sample.chan = ChanW'(s1_jack_q) + ChanW'(1);
    end else begin
      sample.chan = ChanW'(s1_jack_q);
    end
    sample.raw     = s1_raw_q;
    sample.enabled = s1_en_q;
  end

  assign s1_hit     = (32'(s1_jack_q) < 32'(NUM_CHANNELS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && (!s1_hit || out_free);
  assign wr_en      = s1_move && s1_hit;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  mm3fm_chan_state #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .sample_i (sample),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_jack_q <= jack_i;
      s1_raw_q  <= raw_temp_i;
      s1_en_q   <= probe_enabled_i;
    end
    if (wr_en) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_o       = out_q.chan;
  assign filtered_temp_o = out_q.filt;
  assign is_fault_o      = out_q.fault;
  assign change_event_o  = out_q.chg_event;

`ifndef SYNTHESIS
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(channel_o) < 32'(NUM_CHANNELS)))
    else $error("result on a channel outside the configured count");

  a_fault_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_fault_o == (filtered_temp_o <= 0)))
    else $error("fault flag disagrees with filtered temperature");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_hit && out_valid_o && out_stall_i))
    else $error("input stalled with room downstream");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_hit && out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("out-of-range jack produced a result");
`endif

endmodule
